// ===== sv/cos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cos_pkg: shared constants for the circle overlap separation block
// Widths of radii, magnitudes, squares, roots and push quotients.
// ----------------------------------------------------------------------------
package cos_pkg;

	// radius field width (unsigned Q8.8)
	localparam int RAD_W = 16;
	// axis magnitudes that can still collide are below 2^MAG_W
	localparam int MAG_W = 17;
	// squared distance and squared radius sum
	localparam int SQ_W = 2 * MAG_W;
	// integer square root width
	localparam int ROOT_W = MAG_W;
	// push per axis never exceeds half the radius sum
	localparam int Q_W = RAD_W;
	// numerator of the push division: half * magnitude
	localparam int NUM_W = Q_W + MAG_W;
	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== sv/cos_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cos_queue: short first-in first-out queue
// Decouples the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
module cos_queue #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output logic [DW-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/cos_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cos_front: input classification
// Unpacks a circle pair, forms axis differences, magnitudes, direction flags,
// the radius sum and the near test, and hands the entry to the queue.
// ----------------------------------------------------------------------------
module cos_front import cos_pkg::*; #(
	parameter int POS_WIDTH = 24,
	parameter int IN_W      = 128,
	parameter int ENT_W     = 150
) (
	input  wire logic [IN_W-1:0] in_data,
	output logic [ENT_W-1:0]     entry
);

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] fx;
		logic signed [POS_WIDTH-1:0] fy;
		logic signed [POS_WIDTH-1:0] sx;
		logic signed [POS_WIDTH-1:0] sy;
		logic                        gtx;
		logic                        gty;
		logic [MAG_W-1:0]            ax;
		logic [MAG_W-1:0]            ay;
		logic [MAG_W-1:0]            minsum;
		logic                        near;
	} ent_t;

	localparam int O_FX = 0;
	localparam int O_FY = POS_WIDTH;
	localparam int O_FR = 2 * POS_WIDTH;
	localparam int O_SX = 2 * POS_WIDTH + RAD_W;
	localparam int O_SY = 3 * POS_WIDTH + RAD_W;
	localparam int O_SR = 4 * POS_WIDTH + RAD_W;

	logic signed [POS_WIDTH-1:0] fx, fy, sx, sy;
	logic [RAD_W-1:0]            fr, sr;
	logic signed [POS_WIDTH:0]   dx, dy;
	logic [POS_WIDTH:0]          adx, ady;
	ent_t                        e;

	assign fx = in_data[O_FX +: POS_WIDTH];
	assign fy = in_data[O_FY +: POS_WIDTH];
	assign fr = in_data[O_FR +: RAD_W];
	assign sx = in_data[O_SX +: POS_WIDTH];
	assign sy = in_data[O_SY +: POS_WIDTH];
	assign sr = in_data[O_SR +: RAD_W];

	// exact differences and magnitudes
	assign dx  = {sx[POS_WIDTH-1], sx} - {fx[POS_WIDTH-1], fx};
	assign dy  = {sy[POS_WIDTH-1], sy} - {fy[POS_WIDTH-1], fy};
	assign adx = dx[POS_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
	assign ady = dy[POS_WIDTH] ? $unsigned(-dy) : $unsigned(dy);

	// classify
	always_comb begin
		e.fx     = fx;
		e.fy     = fy;
		e.sx     = sx;
		e.sy     = sy;
		e.gtx    = (fx > sx);
		e.gty    = (fy > sy);
		e.ax     = MAG_W'(adx);
		e.ay     = MAG_W'(ady);
		e.minsum = MAG_W'(fr) + MAG_W'(sr);
		e.near   = ((adx >> MAG_W) == '0) && ((ady >> MAG_W) == '0);
	end

	assign entry = e;

endmodule

`default_nettype wire

// ===== sv/cos_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cos_back: separation arithmetic
// Squares, collision test, a one-bit-per-stage square root, half overlap,
// push numerators, two one-bit-per-stage dividers, saturating position update.
// All stages advance together when the output register can take a result.
// ----------------------------------------------------------------------------
module cos_back import cos_pkg::*; #(
	parameter int POS_WIDTH = 24,
	parameter int ENT_W     = 150,
	parameter int OUT_W     = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ent_valid,
	output logic                  ent_ready,
	input  wire logic [ENT_W-1:0] entry,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data,
	output logic                  out_hit
);

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] fx;
		logic signed [POS_WIDTH-1:0] fy;
		logic signed [POS_WIDTH-1:0] sx;
		logic signed [POS_WIDTH-1:0] sy;
		logic                        gtx;
		logic                        gty;
		logic [MAG_W-1:0]            ax;
		logic [MAG_W-1:0]            ay;
		logic [MAG_W-1:0]            minsum;
		logic                        near;
	} ent_t;

	typedef struct packed {
		ent_t e;
		logic hit;
		logic zero;
	} ctx_t;

	typedef struct packed {
		ctx_t              c;
		logic [SQ_W-1:0]   rad;
		logic [ROOT_W+1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		ctx_t              c;
		logic [ROOT_W-1:0] den;
		logic [Q_W-1:0]    half;
		logic [ROOT_W-1:0] remx;
		logic [Q_W-1:0]    lowx;
		logic [Q_W-1:0]    qx;
		logic [ROOT_W-1:0] remy;
		logic [Q_W-1:0]    lowy;
		logic [Q_W-1:0]    qy;
	} dv_t;

	localparam int SW = ((POS_WIDTH > Q_W) ? POS_WIDTH : Q_W) + 2;
	localparam logic signed [SW-1:0] PMAX = (SW'(1) <<< (POS_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

	logic adv;
	assign adv       = !out_valid || out_ready;
	assign ent_ready = adv;

	// saturating add of a push to a position
	function automatic logic signed [POS_WIDTH-1:0] push_sat(
		input logic signed [POS_WIDTH-1:0] p,
		input logic [Q_W-1:0]              q,
		input logic                        up
	);
		logic signed [SW-1:0] s;
		begin
			s = up ? SW'(p) + $signed(SW'(q)) : SW'(p) - $signed(SW'(q));
			if (s > PMAX) begin
				push_sat = PMAX[POS_WIDTH-1:0];
			end else if (s < PMIN) begin
				push_sat = PMIN[POS_WIDTH-1:0];
			end else begin
				push_sat = s[POS_WIDTH-1:0];
			end
		end
	endfunction

	// ---------------- stage 1: squares ----------------
	ent_t            ent_in;
	ent_t            ctx_s1;
	logic [SQ_W-1:0] sqx_s1, sqy_s1, m2_s1;
	logic            v_s1;

	assign ent_in = entry;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ent_in;
			sqx_s1 <= SQ_W'(ent_in.ax) * SQ_W'(ent_in.ax);
			sqy_s1 <= SQ_W'(ent_in.ay) * SQ_W'(ent_in.ay);
			m2_s1  <= SQ_W'(ent_in.minsum) * SQ_W'(ent_in.minsum);
		end
	end

	// ---------------- stage 2: collision test ----------------
	ctx_t              ctx_s2;
	logic [SQ_W-1:0]   rad_s2;
	logic              v_s2;
	logic [SQ_W:0]     d2;

	assign d2 = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2.e    <= ctx_s1;
			ctx_s2.hit  <= ctx_s1.near && (d2 < {1'b0, m2_s1});
			ctx_s2.zero <= (d2 == '0);
			rad_s2      <= d2[SQ_W-1:0];
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	sq_t  sq_in;
	sq_t  sq_s [ROOT_W];
	logic sq_v [ROOT_W];

	always_comb begin
		sq_in.c    = ctx_s2;
		sq_in.rad  = rad_s2;
		sq_in.rem  = '0;
		sq_in.root = '0;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		sq_t               cur;
		logic              cur_v;
		logic [ROOT_W+1:0] pre;
		logic [ROOT_W+1:0] trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur   = sq_in;
			assign cur_v = v_s2;
		end else begin : g_next
			assign cur   = sq_s[k-1];
			assign cur_v = sq_v[k-1];
		end

		assign pre   = {cur.rem[ROOT_W-1:0], cur.rad[2*(ROOT_W-1-k) +: 2]};
		assign trial = {cur.root, 2'b01};
		assign ge    = (pre >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k].c    <= cur.c;
				sq_s[k].rad  <= cur.rad;
				sq_s[k].rem  <= ge ? pre - trial : pre;
				sq_s[k].root <= {cur.root[ROOT_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else if (adv) begin
				sq_v[k] <= cur_v;
			end
		end
	end

	// ---------------- stage 3: half overlap ----------------
	ctx_t              ctx_s3;
	logic [ROOT_W-1:0] dist_s3;
	logic [Q_W-1:0]    half_s3;
	logic              v_s3;
	logic [MAG_W-1:0]  gap;

	assign gap = sq_s[ROOT_W-1].c.e.minsum - sq_s[ROOT_W-1].root;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3  <= sq_s[ROOT_W-1].c;
			dist_s3 <= sq_s[ROOT_W-1].root;
			half_s3 <= gap[MAG_W-1:1];
		end
	end

	// ---------------- stage 4: push numerators ----------------
	ctx_t              ctx_s4;
	logic [ROOT_W-1:0] dist_s4;
	logic [Q_W-1:0]    half_s4;
	logic [NUM_W-1:0]  numx_s4, numy_s4;
	logic              v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4  <= ctx_s3;
			dist_s4 <= dist_s3;
			half_s4 <= half_s3;
			numx_s4 <= NUM_W'(half_s3) * NUM_W'(ctx_s3.e.ax);
			numy_s4 <= NUM_W'(half_s3) * NUM_W'(ctx_s3.e.ay);
		end
	end

	// ---------------- dividers, one quotient bit per stage ----------------
	dv_t  dv_in;
	dv_t  dv_s [Q_W];
	logic dv_v [Q_W];

	always_comb begin
		dv_in.c    = ctx_s4;
		dv_in.den  = dist_s4;
		dv_in.half = half_s4;
		dv_in.remx = numx_s4[NUM_W-1:Q_W];
		dv_in.lowx = numx_s4[Q_W-1:0];
		dv_in.qx   = '0;
		dv_in.remy = numy_s4[NUM_W-1:Q_W];
		dv_in.lowy = numy_s4[Q_W-1:0];
		dv_in.qy   = '0;
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		dv_t             cur;
		logic            cur_v;
		logic [ROOT_W:0] prex, prey, dsor;
		logic            gex, gey;
		logic [ROOT_W:0] subx, suby;

		if (j == 0) begin : g_first
			assign cur   = dv_in;
			assign cur_v = v_s4;
		end else begin : g_next
			assign cur   = dv_s[j-1];
			assign cur_v = dv_v[j-1];
		end

		assign dsor = {1'b0, cur.den};
		assign prex = {cur.remx, cur.lowx[Q_W-1]};
		assign prey = {cur.remy, cur.lowy[Q_W-1]};
		assign gex  = (prex >= dsor);
		assign gey  = (prey >= dsor);
		assign subx = prex - dsor;
		assign suby = prey - dsor;

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j].c    <= cur.c;
				dv_s[j].den  <= cur.den;
				dv_s[j].half <= cur.half;
				dv_s[j].remx <= gex ? subx[ROOT_W-1:0] : prex[ROOT_W-1:0];
				dv_s[j].lowx <= {cur.lowx[Q_W-2:0], 1'b0};
				dv_s[j].qx   <= {cur.qx[Q_W-2:0], gex};
				dv_s[j].remy <= gey ? suby[ROOT_W-1:0] : prey[ROOT_W-1:0];
				dv_s[j].lowy <= {cur.lowy[Q_W-2:0], 1'b0};
				dv_s[j].qy   <= {cur.qy[Q_W-2:0], gey};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (adv) begin
				dv_v[j] <= cur_v;
			end
		end
	end

	// ---------------- output register: position update ----------------
	dv_t                         fin;
	logic                        move;
	logic signed [POS_WIDTH-1:0] nfx, nfy, nsx, nsy;

	assign fin  = dv_s[Q_W-1];
	assign move = fin.c.hit && !fin.c.zero;

	always_comb begin
		if (move) begin
			nfx = push_sat(fin.c.e.fx, fin.qx, fin.c.e.gtx);
			nsx = push_sat(fin.c.e.sx, fin.qx, !fin.c.e.gtx);
			nfy = push_sat(fin.c.e.fy, fin.qy, fin.c.e.gty);
			nsy = push_sat(fin.c.e.sy, fin.qy, !fin.c.e.gty);
		end else begin
			nfx = fin.c.e.fx;
			nsx = fin.c.e.sx;
			nfy = fin.c.e.fy;
			nsy = fin.c.e.sy;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= OUT_W'({nsy, nsx, nfy, nfx});
			out_hit  <= fin.c.hit;
		end
	end

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= ent_valid;
			v_s2      <= v_s1;
			v_s3      <= sq_v[ROOT_W-1];
			v_s4      <= v_s3;
			out_valid <= dv_v[Q_W-1];
		end
	end

	// ---------------- checks ----------------
	// a colliding pair has a root distance below the radius sum
	a_root_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[ROOT_W-1] && sq_s[ROOT_W-1].c.hit
		|-> sq_s[ROOT_W-1].root < sq_s[ROOT_W-1].c.e.minsum)
		else $error("root not below radius sum");

	// distinct centres give a nonzero divisor
	a_dist_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && ctx_s3.hit && !ctx_s3.zero |-> dist_s3 != '0)
		else $error("zero divisor for distinct centres");

	// the push on either axis never exceeds half the overlap
	a_push_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[Q_W-1] && move |-> fin.qx <= fin.half && fin.qy <= fin.half)
		else $error("push exceeds half overlap");

	// the stages stand still while the output is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(dv_v[Q_W-1]) && $stable(v_s1))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== sv/circle_overlap_separation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_overlap_separation: pushes two overlapping circles apart
// Usage:
//   s_* channel: one circle pair per transaction. s_tdata fields from bit 0:
//     first_x, first_y, first_radius, second_x, second_y, second_radius.
//   m_* channel: one result per pair, in order. m_tdata fields from bit 0:
//     new_first_x, new_first_y, new_second_x, new_second_y; m_tuser = collided.
// Throughput: one pair per cycle while m_tready is high.
// Registers from acceptance to m_tvalid through an empty queue:
//   after the queue write come squares, collision test, 17 square root stages
//   (one root bit each), half overlap, push numerators, 16 divider stages (one
//   quotient bit each, both axes side by side) and the output register.
// A 4-entry queue sits between the input classifier and the arithmetic
// pipeline. When m_tvalid is high and m_tready is low the whole pipeline
// holds; the queue then fills and s_tready falls once it is full.
// Reset (arst_n low) empties the queue and clears every stage valid bit.
// ----------------------------------------------------------------------------
module circle_overlap_separation import cos_pkg::*; #(
	parameter int POS_WIDTH = 24,
	localparam int IN_W     = ((4 * POS_WIDTH + 2 * RAD_W + 7) / 8) * 8,
	localparam int OUT_W    = ((4 * POS_WIDTH + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// first_x, first_y, first_radius, second_x, second_y, second_radius
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// new_first_x, new_first_y, new_second_x, new_second_y
	output logic [OUT_W-1:0]      m_tdata,
	// collided
	output logic                  m_tuser
);

	localparam int ENT_W = 4 * POS_WIDTH + 2 + 3 * MAG_W + 1;

	logic [ENT_W-1:0] f_entry;
	logic [ENT_W-1:0] q_entry;
	logic             q_full;
	logic             q_valid;
	logic             b_ready;

	assign s_tready = !q_full;

	cos_front #(
		.POS_WIDTH(POS_WIDTH),
		.IN_W     (IN_W),
		.ENT_W    (ENT_W)
	) u_front (
		.in_data(s_tdata),
		.entry  (f_entry)
	);

	cos_queue #(
		.DW   (ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.push_data(f_entry),
		.full     (q_full),
		.pop      (b_ready),
		.not_empty(q_valid),
		.pop_data (q_entry)
	);

	cos_back #(
		.POS_WIDTH(POS_WIDTH),
		.ENT_W    (ENT_W),
		.OUT_W    (OUT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ent_valid(q_valid),
		.ent_ready(b_ready),
		.entry    (q_entry),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_hit  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== verif/circle_overlap_separation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_separation_checker: result predictor and comparator
// Watches both stream channels, computes the separated positions for every
// accepted circle pair and compares each output transaction in order.
// ----------------------------------------------------------------------------
module circle_overlap_separation_checker #(
	parameter int POS_WIDTH = 24,
	parameter int IN_W      = 128,
	parameter int OUT_W     = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic             m_tuser,
	output int                    fail_count,
	output int                    pending,
	output int                    hit_count
);

	typedef struct packed {
		logic                 collided;
		logic [OUT_W-1:0]     pos;
	} sep_result_t;

	sep_result_t expected_results[$];

	localparam longint POS_HI = (64'sd1 <<< (POS_WIDTH - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;

	function automatic longint sat_pos(longint v);
		if (v > POS_HI) return POS_HI;
		if (v < POS_LO) return POS_LO;
		return v;
	endfunction

	// floor integer square root by binary search
	function automatic longint isqrt(longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'sd1 << 20;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic sep_result_t separate(logic [IN_W-1:0] d);
		longint fx, fy, sx, sy, fr, sr, dx, dy, ax, ay, sum, d2, root_dist, half, px, py;
		sep_result_t r;
		fx = longint'($signed(d[0 +: POS_WIDTH]));
		fy = longint'($signed(d[POS_WIDTH +: POS_WIDTH]));
		fr = longint'(d[2*POS_WIDTH +: 16]);
		sx = longint'($signed(d[2*POS_WIDTH+16 +: POS_WIDTH]));
		sy = longint'($signed(d[3*POS_WIDTH+16 +: POS_WIDTH]));
		sr = longint'(d[4*POS_WIDTH+16 +: 16]);
		dx = sx - fx;
		dy = sy - fy;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		sum = fr + sr;
		r.collided = 1'b0;
		// far-apart pairs skip the squares entirely
		if (ax < 131072 && ay < 131072) begin
			d2 = ax * ax + ay * ay;
			if (d2 < sum * sum) begin
				r.collided = 1'b1;
				if (d2 != 0) begin
					root_dist = isqrt(d2);
					half = (sum - root_dist) / 2;
					px = (half * ax) / root_dist;
					py = (half * ay) / root_dist;
					if (fx > sx) begin fx += px; sx -= px; end
					else begin fx -= px; sx += px; end
					if (fy > sy) begin fy += py; sy -= py; end
					else begin fy -= py; sy += py; end
					fx = sat_pos(fx); fy = sat_pos(fy);
					sx = sat_pos(sx); sy = sat_pos(sy);
				end
			end
		end
		r.pos = '0;
		r.pos[0 +: POS_WIDTH]           = fx[POS_WIDTH-1:0];
		r.pos[POS_WIDTH +: POS_WIDTH]   = fy[POS_WIDTH-1:0];
		r.pos[2*POS_WIDTH +: POS_WIDTH] = sx[POS_WIDTH-1:0];
		r.pos[3*POS_WIDTH +: POS_WIDTH] = sy[POS_WIDTH-1:0];
		return r;
	endfunction

	assign pending = expected_results.size();

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		sep_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			fail_count <= 0;
			hit_count  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(separate(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transaction tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.collided) hit_count <= hit_count + 1;
					if (want.pos !== m_tdata || want.collided !== m_tuser) begin
						$display("%0t: mismatch expected tdata=%h tuser=%b actual tdata=%h tuser=%b",
							$time, want.pos, want.collided, m_tdata, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_circle_overlap_separation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_overlap_separation: stimulus and verdict
// Drives directed and random circle pairs with random gaps and back pressure;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_circle_overlap_separation;

	localparam int POS_WIDTH = 24;
	localparam int IN_W  = ((4 * POS_WIDTH + 32 + 7) / 8) * 8;
	localparam int OUT_W = ((4 * POS_WIDTH + 7) / 8) * 8;
	localparam int LATENCY = 38;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// first_x, first_y, first_radius, second_x, second_y, second_radius
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// new_first_x, new_first_y, new_second_x, new_second_y
	logic [OUT_W-1:0] m_tdata;
	// collided
	logic m_tuser;
	int fail_count, pending, hit_count;
	longint cycles = 0;
	int sent = 0;
	bit idle_free = 0;

	always #5 clk = ~clk;

	circle_overlap_separation #(.POS_WIDTH(POS_WIDTH)) u_top (.*);

	circle_overlap_separation_checker #(
		.POS_WIDTH(POS_WIDTH), .IN_W(IN_W), .OUT_W(OUT_W)
	) u_chk (.*);

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls drawn per transaction
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = idle_free ? 0 : $urandom_range(0, 11);
			if (m_tready && w != 0) m_tready <= 1'b0;
			repeat (w) @(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [IN_W-1:0] pack_pair(logic [23:0] fx, logic [23:0] fy,
			logic [15:0] fr, logic [23:0] sx, logic [23:0] sy, logic [15:0] sr);
		logic [IN_W-1:0] d;
		d = '0;
		d[0 +: 24] = fx; d[24 +: 24] = fy; d[48 +: 16] = fr;
		d[64 +: 24] = sx; d[88 +: 24] = sy; d[112 +: 16] = sr;
		return d;
	endfunction

	task automatic send_pair(logic [IN_W-1:0] d);
		int w;
		w = idle_free ? 0 : $urandom_range(0, 11);
		if (w != 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// mostly near pairs so that collisions are common
	function automatic logic [IN_W-1:0] random_pair();
		logic [23:0] fx, fy, sx, sy;
		logic [15:0] fr, sr;
		int mode;
		mode = $urandom_range(0, 9);
		fx = 24'($urandom); fy = 24'($urandom);
		fr = 16'($urandom); sr = 16'($urandom);
		if (mode == 0) begin
			sx = 24'($urandom); sy = 24'($urandom);
		end else if (mode == 1) begin
			// near the saturation limits
			fx = {~fx[23], {23{fx[23]}}} ^ 24'($urandom_range(0, 255));
			sx = 24'(fx + $urandom_range(0, 511) - 256);
			sy = 24'(fy + $urandom_range(0, 511) - 256);
		end else if (mode == 2) begin
			sx = fx; sy = 24'(fy + $signed($urandom_range(0, 2000)) - 1000);
		end else begin
			sx = 24'(fx + $signed($urandom_range(0, 262143)) - 131072);
			sy = 24'(fy + $signed($urandom_range(0, 262143)) - 131072);
			if (mode > 5) begin
				sx = 24'(fx + $signed($urandom_range(0, 8191)) - 4096);
				sy = 24'(fy + $signed($urandom_range(0, 8191)) - 4096);
			end
		end
		return pack_pair(fx, fy, fr, sx, sy, sr);
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extremes, coincident centres, equal axis, far apart, limits
		send_pair(pack_pair(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'h0));
		send_pair(pack_pair(24'h0, 24'h0, 16'h100, 24'h0, 24'h0, 16'h100));
		send_pair(pack_pair(24'h0, 24'h0, 16'hffff, 24'h100, 24'h0, 16'hffff));
		send_pair(pack_pair(24'h0, 24'h200, 16'hffff, 24'h0, 24'h0, 16'hffff));
		send_pair(pack_pair(24'h7fffff, 24'h7fffff, 16'hffff, 24'h7ffff0, 24'h7ffff0,
			16'hffff));
		send_pair(pack_pair(24'h800000, 24'h800000, 16'hffff, 24'h800010, 24'h800010,
			16'hffff));
		send_pair(pack_pair(24'h0, 24'h0, 16'hffff, 24'h20000, 24'h0, 16'hffff));
		send_pair(pack_pair(24'h0, 24'h0, 16'hffff, 24'h1ffff, 24'h0, 16'hffff));
		send_pair(pack_pair(24'h7fffff, 24'h0, 16'hffff, 24'h800000, 24'h0, 16'hffff));
		send_pair(pack_pair(24'h0, 24'h0, 16'h100, 24'h200, 24'h0, 16'h100));
		send_pair(pack_pair(24'h0, 24'h0, 16'h100, 24'h1ff, 24'h0, 16'h100));
		send_pair(pack_pair(24'h100, 24'h100, 16'h80, 24'hff, 24'hff, 16'h80));
		send_pair(pack_pair(24'hffffff, 24'h000001, 16'h1, 24'h000001, 24'hffffff, 16'h1));
		for (int i = 0; i < 1950; i++) begin
			idle_free = (i >= 700 && i < 900);
			send_pair(random_pair());
		end
		s_tvalid <= 1'b0;
		idle_free = 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("tb: %0d circle pairs sent, %0d collisions checked", sent, hit_count);
		$display("tb: covered coincident centres, single-axis pushes, far pairs, saturation");
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
